/* sv/circular_fifo_queue_macros.svh */
// ----------------------------------------------------------------------------
// circular_fifo_queue_macros : assertion macros
// Shared concurrent assertion wrappers for the circular FIFO queue.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_FIFO_QUEUE_MACROS_SVH
`define CIRCULAR_FIFO_QUEUE_MACROS_SVH

// Implication check, clocked on clk, held off while rst_n is low.
`define CFQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true.
`define CFQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* sv/cfq_pkg.sv */
// ----------------------------------------------------------------------------
// cfq_pkg : circular FIFO queue package
// Depth, widths, operation and status codes, controller types.
// ----------------------------------------------------------------------------
`default_nettype none

package cfq_pkg;

  localparam int MaxDepth = 16;
  localparam int PtrW     = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
  localparam int CntW     = $clog2(MaxDepth + 1);
  localparam int CapW     = 5;
  localparam int DataW    = 32;

  localparam logic signed [DataW-1:0] IntMin = {1'b1, {(DataW-1){1'b0}}};

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [1:0] {
    OpEnq       = 2'd0,
    OpDeq       = 2'd1,
    OpPeekFront = 2'd2,
    OpPeekRear  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef enum logic {
    StateIdle,
    StateExec
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // latch request, launch entry read
    logic exec;  // apply operation, register result
  } cmd_t;

  // Advance a pointer, wrapping at the capacity
  function automatic ptr_t wrap_next(ptr_t idx, cnt_t cap);
    logic [PtrW:0] n;
    n = {1'b0, idx} + {{PtrW{1'b0}}, 1'b1};
    if (CntW'(n) >= cap) begin
      wrap_next = '0;
    end else begin
      wrap_next = n[PtrW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* sv/cfq_ctrl.sv */
// ----------------------------------------------------------------------------
// cfq_ctrl : circular FIFO queue controller
// Two-state sequencer: accept a request, then execute it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output cfq_pkg::cmd_t      cmd_o,
  output logic               busy_o,
  output logic               valid_o
);

  cfq_pkg::state_e state_q, state_d;
  logic            done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cfq_pkg::StateIdle: begin
        if (start_i) begin
          state_d = cfq_pkg::StateExec;
        end
      end
      cfq_pkg::StateExec: begin
        state_d = cfq_pkg::StateIdle;
      end
      default: begin
        state_d = cfq_pkg::StateIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b0;
    unique case (state_q)
      cfq_pkg::StateIdle: begin
        cmd_o.load = start_i;
      end
      cfq_pkg::StateExec: begin
        cmd_o.exec = 1'b1;
        busy_o     = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfq_pkg::StateIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.exec;
    end
  end

  assign valid_o = done_q;

endmodule

`default_nettype wire

/* sv/cfq_datapath.sv */
// ----------------------------------------------------------------------------
// cfq_datapath : circular FIFO queue datapath
// Entry memory, head/tail pointers, count, capacity and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cfq_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire cfq_pkg::cmd_t                     cmd_i,
  input  wire logic [1:0]                        opcode_i,
  input  wire logic signed [cfq_pkg::DataW-1:0]  data_in_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [cfq_pkg::CapW-1:0]          cfg_wdata_i,
  output logic signed [cfq_pkg::DataW-1:0]       value_out_o,
  output logic [1:0]                             status_o,
  output logic [cfq_pkg::CntW-1:0]               occupancy_o,
  output logic                                   full_flag_o,
  output logic                                   empty_flag_o
);

  logic signed [cfq_pkg::DataW-1:0] mem [cfq_pkg::MaxDepth];

  cfq_pkg::ptr_t head_q, head_d, tail_q, tail_d, rd_addr;
  cfq_pkg::cnt_t cnt_q, cnt_d, cap_q, cap_sat;
  cfq_pkg::op_e  op_q;
  logic signed [cfq_pkg::DataW-1:0] data_q, rd_q;

  logic                             wr_en;
  logic signed [cfq_pkg::DataW-1:0] val_d;
  cfq_pkg::status_e                 st_d;
  logic                             is_full, is_empty;

  // Capacity saturates into 1..MaxDepth
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cap_sat = cfq_pkg::CntW'(1);
    end else if (32'(cfg_wdata_i) > cfq_pkg::MaxDepth) begin
      cap_sat = cfq_pkg::CntW'(cfq_pkg::MaxDepth);
    end else begin
      cap_sat = cfq_pkg::CntW'(cfg_wdata_i);
    end
  end

  assign rd_addr = (cfq_pkg::op_e'(opcode_i) == cfq_pkg::OpPeekRear) ? tail_q : head_q;

  assign is_full  = (cnt_q >= cap_q);
  assign is_empty = (cnt_q == '0);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    wr_en  = 1'b0;
    val_d  = cfq_pkg::IntMin;
    st_d   = cfq_pkg::StOk;
    case (op_q)
      cfq_pkg::OpEnq: begin
        if (is_full) begin
          st_d = cfq_pkg::StFull;
        end else begin
          tail_d = cfq_pkg::wrap_next(tail_q, cap_q);
          wr_en  = 1'b1;
          cnt_d  = cnt_q + cfq_pkg::CntW'(1);
          val_d  = data_q;
        end
      end
      cfq_pkg::OpDeq: begin
        if (is_empty) begin
          st_d = cfq_pkg::StEmpty;
        end else begin
          val_d  = rd_q;
          head_d = cfq_pkg::wrap_next(head_q, cap_q);
          cnt_d  = cnt_q - cfq_pkg::CntW'(1);
        end
      end
      default: begin
        // peek front or rear: address picked at accept
        if (is_empty) begin
          st_d = cfq_pkg::StEmpty;
        end else begin
          val_d = rd_q;
        end
      end
    endcase
  end

  // Entry memory: read at accept, write at execute
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_q <= mem[rd_addr];
    end
    if (cmd_i.exec && wr_en) begin
      mem[tail_d] <= data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= cfq_pkg::op_e'(opcode_i);
      data_q <= data_in_i;
    end
    if (cmd_i.exec) begin
      value_out_o  <= val_d;
      status_o     <= st_d;
      occupancy_o  <= cnt_d;
      full_flag_o  <= (cnt_d == cap_q);
      empty_flag_o <= (cnt_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= cfq_pkg::CntW'(cfq_pkg::MaxDepth);
      head_q <= '0;
      tail_q <= cfq_pkg::PtrW'(cfq_pkg::MaxDepth - 1);
      cnt_q  <= '0;
    end else if (cfg_we_i) begin
      cap_q  <= cap_sat;
      head_q <= '0;
      tail_q <= cfq_pkg::PtrW'(cap_sat - cfq_pkg::CntW'(1));
      cnt_q  <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* sv/circular_fifo_queue.sv */
// ----------------------------------------------------------------------------
// circular_fifo_queue : ring-buffer FIFO of signed 32-bit words
// Enqueue, dequeue, peek front and peek rear, with a writable capacity.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                   Handshake
// request   start_i, opcode_i, data_in_i              taken when start_i && !busy_o
// result    value_out_o, status_o, occupancy_o,       one cycle, valid_o strobe
//           full_flag_o, empty_flag_o
// config    cfg_we_i, cfg_wdata_i                     taken when cfg_we_i
//
// Each request is accepted, then executed: the accept cycle launches the entry read
// (registered memory port), the execute cycle updates pointers and count and
// registers the result. busy_o is high during execute only; valid_o pulses the
// cycle after execute, while a new request may already be accepted.
// Reset (rst_ni low) empties the queue and sets capacity to full depth.
// The result cannot be stalled; it is presented once.
//
`default_nettype none

module circular_fifo_queue (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [1:0]                        opcode_i,
  input  wire logic signed [cfq_pkg::DataW-1:0]  data_in_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [cfq_pkg::CapW-1:0]          cfg_wdata_i,
  output logic                                   valid_o,
  output logic signed [cfq_pkg::DataW-1:0]       value_out_o,
  output logic [1:0]                             status_o,
  output logic [cfq_pkg::CntW-1:0]               occupancy_o,
  output logic                                   full_flag_o,
  output logic                                   empty_flag_o
);

  `include "circular_fifo_queue_macros.svh"

  cfq_pkg::cmd_t cmd;

  // Sequencer: accept, then execute
  cfq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .valid_o (valid_o)
  );

  // Storage, pointers and result registers
  cfq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .opcode_i     (opcode_i),
    .data_in_i    (data_in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .value_out_o  (value_out_o),
    .status_o     (status_o),
    .occupancy_o  (occupancy_o),
    .full_flag_o  (full_flag_o),
    .empty_flag_o (empty_flag_o)
  );

  // Every accepted request yields its result, strobed on valid_o after execute
  `CFQ_ASSERT(a_req_to_result, clk_i, rst_ni, (start_i && !busy_o) |-> ##2 valid_o, "result missing after request")

  // Execute lasts exactly one cycle
  `CFQ_ASSERT(a_busy_one_cycle, clk_i, rst_ni, busy_o |=> !busy_o, "busy held past execute")

  // Capacity is at least one, so full and empty never coincide
  `CFQ_ASSERT_NEVER(a_full_and_empty, clk_i, rst_ni, valid_o && full_flag_o && empty_flag_o, "full and empty together")

  // Errors always carry the minimum value
  `CFQ_ASSERT(a_err_value, clk_i, rst_ni, (valid_o && (status_o != cfq_pkg::StOk)) |-> (value_out_o == cfq_pkg::IntMin), "error result value wrong")

endmodule

`default_nettype wire
